// ===== rtl/npc_pkg.sv =====
// Shared types and constants for the nearest palette color unit.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int IDX_W           = 8;
    localparam int END_W           = 9;
    localparam int COLOR_W         = 8;
    localparam int ENTRY_W         = 3 * COLOR_W;
    localparam int SQ_W            = 2 * COLOR_W;
    localparam int DIST_W          = SQ_W + 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [END_W-1:0] PALETTE_END = END_W'(PALETTE_ENTRIES);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_en;
        logic             start;
        logic [IDX_W-1:0] first;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_palette_color_unit.sv =====
// Nearest palette color unit: top level joining the controller and the datapath.
//
// Input channel (s_valid/s_ready): a beat with s_mode = load writes s_red, s_green and
// s_blue into palette entry s_entry_index and gives no result.
// A beat with s_mode = query searches palette indices first_index up to, but not
// including, end_index (clamped to the palette size) for the entry with the smallest
// squared RGB distance, the lowest index winning ties. An empty range returns first_index.
// Output channel (m_valid/m_ready): one beat per query carrying m_best_index.
// Configuration channel (cfg_valid/cfg_ready): index 0 writes first_index, index 1
// writes end_index; other indices are ignored. Write it only while the unit is idle.
// A query holds the input channel from its accepting edge until the result register is
// loaded. The scan reads one palette entry per cycle from the single memory read port; a
// two-stage distance pipeline follows it. Loads are accepted back to back.
// A finished result waits in the output register; further loads are taken meanwhile,
// and a following query completes its scan but holds until the register is free.
// Reset sets first_index to 0, end_index to 256 and empties the output register;
// palette contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_unit
    import npc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [IDX_W-1:0]     s_entry_index,
    input  wire logic [COLOR_W-1:0]   s_red,
    input  wire logic [COLOR_W-1:0]   s_green,
    input  wire logic [COLOR_W-1:0]   s_blue,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [IDX_W-1:0]          m_best_index,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [END_W-1:0]     cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    npc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    npc_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_entry_index (s_entry_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .stat          (stat),
        .m_best_index  (m_best_index)
    );

`ifndef ASSERT_OFF
    // The result is never captured while distance beats are still in the pipeline.
    a_load_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.busy)
        else $error("result captured before the pipeline drained");

    // A query beat blocks the input channel on the following cycle.
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_QUERY) |=> !s_ready)
        else $error("input accepted right after a query beat");

    // Palette writes and scan reads never overlap.
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (!cmd.wr_en && !s_ready))
        else $error("palette write or input accepted during a scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/npc_ctrl.sv =====
// Controller: configuration registers, scan sequencer and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module npc_ctrl
    import npc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [END_W-1:0]     cfg_wdata,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire stat_t                stat,
    output cmd_t                      cmd
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  first_index_reg, first_index_next;
    logic [END_W-1:0]  end_index_reg, end_index_next;
    logic [END_W-1:0]  end_lim_reg, end_lim_next;
    logic [END_W-1:0]  addr_reg, addr_next;
    logic              m_valid_reg, m_valid_next;
    logic [END_W-1:0]  end_clamped;
    logic              range_empty;
    logic              in_beat;
    logic              out_free;

    assign end_clamped = (end_index_reg > PALETTE_END) ? PALETTE_END : end_index_reg;
    assign range_empty = ({1'b0, first_index_reg} >= end_clamped);
    assign in_beat     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && s_mode == MODE_QUERY) begin
                    state_next = range_empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (addr_reg + END_W'(1) == end_lim_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cfg_ready    = 1'b1;
        m_valid      = m_valid_reg;
        cmd.wr_en    = 1'b0;
        cmd.start    = 1'b0;
        cmd.first    = first_index_reg;
        cmd.rd_en    = 1'b0;
        cmd.rd_idx   = addr_reg[IDX_W-1:0];
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.wr_en = in_beat && (s_mode == MODE_LOAD);
                cmd.start = in_beat && (s_mode == MODE_QUERY);
            end
            ST_SCAN:   cmd.rd_en    = 1'b1;
            ST_DRAIN:  cmd.rd_en    = 1'b0;
            ST_FINISH: cmd.out_load = out_free;
            default:   cmd.rd_en    = 1'b0;
        endcase
    end

    // Data next values.
    always_comb begin
        first_index_next = first_index_reg;
        end_index_next   = end_index_reg;
        end_lim_next     = end_lim_reg;
        addr_next        = addr_reg;
        m_valid_next     = m_valid_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FIRST_INDEX) begin
                first_index_next = cfg_wdata[IDX_W-1:0];
            end else if (cfg_index == CFG_END_INDEX) begin
                end_index_next = cfg_wdata;
            end
        end
        if (cmd.start) begin
            end_lim_next = end_clamped;
            addr_next    = {1'b0, first_index_reg};
        end else if (cmd.rd_en) begin
            addr_next = addr_reg + END_W'(1);
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            first_index_reg <= '0;
            end_index_reg   <= PALETTE_END;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            first_index_reg <= first_index_next;
            end_index_reg   <= end_index_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_lim_reg <= end_lim_next;
        addr_reg    <= addr_next;
    end

endmodule

`default_nettype wire

// ===== rtl/npc_dpath.sv =====
// Datapath: palette memory, distance pipeline, best-match tracking, result register.
`timescale 1ns / 1ps
`default_nettype none

module npc_dpath
    import npc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    input  wire logic [IDX_W-1:0]   s_entry_index,
    input  wire logic [COLOR_W-1:0] s_red,
    input  wire logic [COLOR_W-1:0] s_green,
    input  wire logic [COLOR_W-1:0] s_blue,
    output stat_t                   stat,
    output logic [IDX_W-1:0]        m_best_index
);

    logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];

    logic [COLOR_W-1:0] q_red_reg, q_green_reg, q_blue_reg;
    logic [ENTRY_W-1:0] s1_data_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_valid_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic               s2_valid_reg;
    logic               have_reg, have_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               wr_in_range;
    logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
    logic [COLOR_W-1:0] e_red, e_green, e_blue;
    logic [DIST_W-1:0]  dist_sum;

    assign wr_in_range = ({1'b0, s_entry_index} < PALETTE_END);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_in_range) begin
            mem[s_entry_index[ADDR_W-1:0]] <= {s_red, s_green, s_blue};
        end
        if (cmd.rd_en) begin
            s1_data_reg <= mem[cmd.rd_idx[ADDR_W-1:0]];
        end
    end

    assign e_red   = s1_data_reg[ENTRY_W-1 -: COLOR_W];
    assign e_green = s1_data_reg[SQ_W-1 -: COLOR_W];
    assign e_blue  = s1_data_reg[COLOR_W-1:0];
    assign diff_r  = (q_red_reg   > e_red)   ? q_red_reg   - e_red   : e_red   - q_red_reg;
    assign diff_g  = (q_green_reg > e_green) ? q_green_reg - e_green : e_green - q_green_reg;
    assign diff_b  = (q_blue_reg  > e_blue)  ? q_blue_reg  - e_blue  : e_blue  - q_blue_reg;

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    // Strict less-than keeps the lowest index on ties, so the scan never needs to stop early.
    always_comb begin
        have_next      = have_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (cmd.start) begin
            have_next     = 1'b0;
            best_idx_next = cmd.first;
        end else if (s2_valid_reg && (!have_reg || dist_sum < best_dist_reg)) begin
            have_next      = 1'b1;
            best_dist_next = dist_sum;
            best_idx_next  = s2_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
            have_reg     <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_red_reg   <= s_red;
            q_green_reg <= s_green;
            q_blue_reg  <= s_blue;
        end
        s1_idx_reg    <= cmd.rd_idx;
        sq_r_reg      <= SQ_W'(diff_r) * SQ_W'(diff_r);
        sq_g_reg      <= SQ_W'(diff_g) * SQ_W'(diff_g);
        sq_b_reg      <= SQ_W'(diff_b) * SQ_W'(diff_b);
        s2_idx_reg    <= s1_idx_reg;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (cmd.out_load) begin
            out_idx_reg <= best_idx_reg;
        end
    end

    assign stat.busy    = s1_valid_reg || s2_valid_reg;
    assign m_best_index = out_idx_reg;

endmodule

`default_nettype wire
